// ===== hw/rtl/tbpr_pkg.sv =====
`default_nettype none

package tbpr_pkg;

    localparam int POSITION_BITS = 12;
    localparam int POS_W         = POSITION_BITS;
    localparam int POS_LIMIT     = (2 ** POS_W) - 1;
    localparam int CAP_W         = 12;
    localparam int WPOS_W        = 12;
    localparam int RUN_W         = 9;
    localparam int CMP_W         = ((POS_W > CAP_W) ? POS_W : CAP_W) + 1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(720);

    localparam logic [RUN_W-1:0] RUN3_BASE = RUN_W'(3);
    localparam logic [RUN_W-1:0] RUN4_BASE = RUN_W'(12);
    localparam logic [RUN_W-1:0] RUN8_BASE = RUN_W'(29);

    localparam logic [3:0] RUN3_BITS = 4'd3;
    localparam logic [3:0] RUN4_BITS = 4'd4;
    localparam logic [3:0] RUN8_BITS = 4'd8;
    localparam logic [3:0] PIX_BITS  = 4'd2;

    localparam logic [1:0] SW_END  = 2'b00;
    localparam logic [1:0] SW_TWO  = 2'b01;
    localparam logic [1:0] SW_RUN4 = 2'b10;

    typedef enum logic [9:0] {
        PH_CODE_A = 10'b00_0000_0001,
        PH_CODE_B = 10'b00_0000_0010,
        PH_SW1    = 10'b00_0000_0100,
        PH_SW2    = 10'b00_0000_1000,
        PH_SW3_A  = 10'b00_0001_0000,
        PH_SW3_B  = 10'b00_0010_0000,
        PH_RUN3   = 10'b00_0100_0000,
        PH_RUN4   = 10'b00_1000_0000,
        PH_RUN8   = 10'b01_0000_0000,
        PH_PIX    = 10'b10_0000_0000
    } tbpr_phase_t;

    typedef struct packed {
        logic stream_bit;
        logic start_of_string;
    } tbpr_item_t;

    typedef struct packed {
        logic [1:0]        pixel_code;
        logic [RUN_W-1:0]  run_length;
        logic [WPOS_W-1:0] write_position;
        logic [RUN_W-1:0]  written_length;
        logic              end_of_string;
    } tbpr_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tbpr_if.sv =====
`default_nettype none

interface tbpr_stream_if;
    import tbpr_pkg::*;
    logic       valid;
    logic       ready;
    tbpr_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tbpr_run_if;
    import tbpr_pkg::*;
    logic         valid;
    logic         ready;
    tbpr_result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tbpr_cfg_if;
    import tbpr_pkg::*;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tbpr_in_reg.sv =====
`default_nettype none

module tbpr_in_reg
    import tbpr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tbpr_stream_if.sink stream,
    input  wire logic   advance,
    output logic        item_valid,
    output tbpr_item_t  item
);

    logic       valid_reg;
    logic       valid_next;
    tbpr_item_t item_reg;
    logic       accept;

    assign stream.ready = !valid_reg || advance;
    assign accept       = stream.valid && stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= stream.data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tbpr_parser.sv =====
`default_nettype none

module tbpr_parser
    import tbpr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire tbpr_item_t       item,
    input  wire logic [CAP_W-1:0] capacity,
    output logic                  has_result,
    output tbpr_result_t          result
);

    tbpr_phase_t      phase_reg, phase_next;
    logic [3:0]       remain_reg, remain_next;
    logic [7:0]       acc_reg, acc_next;
    logic [RUN_W-1:0] held_reg, held_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    tbpr_phase_t      phase_cur;
    logic [3:0]       remain_cur;
    logic [7:0]       acc_cur;
    logic [POS_W-1:0] pos_cur;
    logic [7:0]       acc_shift;
    logic [3:0]       remain_dec;
    logic [1:0]       code2;

    logic             emit_run;
    logic             emit_end;
    logic [1:0]       run_pix;
    logic [RUN_W-1:0] run_len;

    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] room;
    logic [RUN_W-1:0] written;

    always_comb
    begin
        phase_cur  = item.start_of_string ? PH_CODE_A : phase_reg;
        remain_cur = item.start_of_string ? 4'd0 : remain_reg;
        acc_cur    = item.start_of_string ? 8'd0 : acc_reg;
        pos_cur    = item.start_of_string ? '0 : pos_reg;
        acc_shift  = {acc_cur[6:0], item.stream_bit};
        remain_dec = remain_cur - 4'd1;
        code2      = {acc_cur[0], item.stream_bit};
    end

    // capacity clip
    always_comb
    begin
        cap_ext = CMP_W'(capacity);
        eff_cap = (cap_ext < CMP_W'(POS_LIMIT)) ? cap_ext : CMP_W'(POS_LIMIT);
        pos_ext = CMP_W'(pos_cur);
        room    = eff_cap - pos_ext;
        written = '0;
        if (pos_ext < eff_cap)
        begin
            written = (CMP_W'(run_len) < room) ? run_len : room[RUN_W-1:0];
        end
    end

    always_comb
    begin
        phase_next  = phase_cur;
        remain_next = remain_cur;
        acc_next    = acc_cur;
        held_next   = held_reg;
        emit_run    = 1'b0;
        emit_end    = 1'b0;
        run_pix     = 2'd0;
        run_len     = '0;
        case (phase_cur)
            PH_CODE_A:
            begin
                acc_next   = {7'd0, item.stream_bit};
                phase_next = PH_CODE_B;
            end
            PH_CODE_B:
            begin
                if (code2 != 2'd0)
                begin
                    emit_run = 1'b1;
                    run_pix  = code2;
                    run_len  = RUN_W'(1);
                end
                else
                begin
                    phase_next = PH_SW1;
                end
            end
            PH_SW1:
            begin
                if (item.stream_bit)
                begin
                    phase_next  = PH_RUN3;
                    remain_next = RUN3_BITS;
                    acc_next    = 8'd0;
                end
                else
                begin
                    phase_next = PH_SW2;
                end
            end
            PH_SW2:
            begin
                if (item.stream_bit)
                begin
                    emit_run = 1'b1;
                    run_len  = RUN_W'(1);
                end
                else
                begin
                    phase_next = PH_SW3_A;
                end
            end
            PH_SW3_A:
            begin
                acc_next   = {7'd0, item.stream_bit};
                phase_next = PH_SW3_B;
            end
            PH_SW3_B:
            begin
                if (code2 == SW_END)
                begin
                    emit_end = 1'b1;
                end
                else if (code2 == SW_TWO)
                begin
                    emit_run = 1'b1;
                    run_len  = RUN_W'(2);
                end
                else if (code2 == SW_RUN4)
                begin
                    phase_next  = PH_RUN4;
                    remain_next = RUN4_BITS;
                    acc_next    = 8'd0;
                end
                else
                begin
                    phase_next  = PH_RUN8;
                    remain_next = RUN8_BITS;
                    acc_next    = 8'd0;
                end
            end
            PH_RUN3, PH_RUN4, PH_RUN8, PH_PIX:
            begin
                acc_next    = acc_shift;
                remain_next = remain_dec;
                if (remain_dec == 4'd0)
                begin
                    if (phase_cur == PH_PIX)
                    begin
                        emit_run = 1'b1;
                        run_pix  = acc_shift[1:0];
                        run_len  = held_reg;
                    end
                    else
                    begin
                        if (phase_cur == PH_RUN3)
                        begin
                            held_next = RUN3_BASE + RUN_W'(acc_shift[2:0]);
                        end
                        else if (phase_cur == PH_RUN4)
                        begin
                            held_next = RUN4_BASE + RUN_W'(acc_shift[3:0]);
                        end
                        else
                        begin
                            held_next = RUN8_BASE + RUN_W'(acc_shift);
                        end
                        phase_next  = PH_PIX;
                        remain_next = PIX_BITS;
                        acc_next    = 8'd0;
                    end
                end
            end
            default:
            begin
                phase_next  = PH_CODE_A;
                remain_next = 4'd0;
                acc_next    = 8'd0;
            end
        endcase

        if (emit_run || emit_end)
        begin
            phase_next  = PH_CODE_A;
            remain_next = 4'd0;
            acc_next    = 8'd0;
        end
    end

    always_comb
    begin
        pos_next = pos_cur;
        if (emit_run)
        begin
            pos_next = pos_cur + POS_W'(written);
        end
        else if (emit_end)
        begin
            pos_next = '0;
        end
    end

    always_comb
    begin
        has_result            = emit_run || emit_end;
        result.pixel_code     = run_pix;
        result.run_length     = run_len;
        result.write_position = WPOS_W'(pos_cur);
        result.written_length = emit_run ? written : '0;
        result.end_of_string  = emit_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_CODE_A;
            remain_reg <= 4'd0;
            acc_reg    <= 8'd0;
            held_reg   <= '0;
            pos_reg    <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            acc_reg    <= acc_next;
            held_reg   <= held_next;
            pos_reg    <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/tbpr_out_reg.sv =====
`default_nettype none

module tbpr_out_reg
    import tbpr_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire tbpr_result_t result,
    output logic              full,
    tbpr_run_if.source        run
);

    logic         valid_reg;
    logic         valid_next;
    tbpr_result_t data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (run.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign run.valid = valid_reg;
    assign run.data  = data_reg;
    assign full      = valid_reg && !run.ready;

endmodule

`default_nettype wire

// ===== hw/rtl/two_bit_pixel_run_decoder_top.sv =====
// channel  | role   | payload
// ---------+--------+------------------------------------------------------------
// stream   | sink   | stream_bit, start_of_string (one code string bit per item)
// run      | source | pixel_code, run_length, write_position, written_length,
//          |        | end_of_string
// cfg      | sink   | line_capacity (12 bits), always ready
//
// One item per clock sustained while the run channel does not back-pressure. An
// item is held in the input register and parsed; its result, if any, is registered
// in the result register, which drives run.valid. The parser steps only when the
// result register is empty or being drained.
// Reset clears parser state, position, valid flags; line_capacity resets to 720.
`default_nettype none

module two_bit_pixel_run_decoder_top
    import tbpr_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tbpr_stream_if.sink stream,
    tbpr_run_if.source  run,
    tbpr_cfg_if.sink    cfg
);

    logic             item_valid;
    tbpr_item_t       item;
    logic             advance;
    logic             out_full;
    logic             has_result;
    tbpr_result_t     result;
    logic [CAP_W-1:0] capacity_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg.valid)
        begin
            capacity_reg <= cfg.data;
        end
    end

    assign advance = item_valid && !out_full;

    tbpr_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tbpr_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item       (item),
        .capacity   (capacity_reg),
        .has_result (has_result),
        .result     (result)
    );

    tbpr_out_reg u_out_reg (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance && has_result),
        .result (result),
        .full   (out_full),
        .run    (run)
    );

endmodule

`default_nettype wire
